[sv/wtm_pkg.sv]
// Package for the four-voice wavetable mixer: sizes, codes, states and the
// request and response structs of the loop remainder unit.
// Depends on nothing; every other file uses it by scoped names.
package wtm_pkg;

    localparam int VOICES           = 4;
    localparam int SAMPLE_ADDR_BITS = 16;
    localparam int FRAC_BITS        = 12;

    localparam int POS_W   = 28;
    localparam int RATE_W  = 24;
    localparam int VOL_W   = 6;
    localparam int BASE_W  = 16;
    localparam int LOOP_W  = 16;
    localparam int SAMP_W  = 8;
    localparam int IDX_W   = POS_W - FRAC_BITS;
    localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int EXT_W   = POS_W + LOOP_W + FRAC_BITS;
    localparam int DIFF_W  = SAMP_W + 1;
    localparam int PROD_W  = DIFF_W + FRAC_BITS + 1;
    localparam int ACC_W   = 20;
    localparam int MIX_W   = 16;
    localparam int CNT_W   = $clog2(IDX_W + 1);

    localparam logic signed [ACC_W-1:0] MIX_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] MIX_MIN = -ACC_W'(32767);

    localparam logic [1:0] OP_WRITE_SAMPLE = 2'd0;
    localparam logic [1:0] OP_WRITE_VOICE  = 2'd1;
    localparam logic [1:0] OP_MIX          = 2'd2;

    localparam logic [2:0] REG_BASE       = 3'd0;
    localparam logic [2:0] REG_POSITION   = 3'd1;
    localparam logic [2:0] REG_RATE       = 3'd2;
    localparam logic [2:0] REG_VOLUME     = 3'd3;
    localparam logic [2:0] REG_LOOP_BEGIN = 3'd4;
    localparam logic [2:0] REG_LOOP_END   = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_INTERP,
        S_SCALE,
        S_ACCUM,
        S_OUTPUT,
        S_ADVANCE,
        S_MOD_WAIT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [IDX_W-1:0]  dividend;
        logic [LOOP_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [LOOP_W-1:0] rem;
    } mod_rsp_t;

endpackage

[sv/wtm_in_if.sv]
// Input channel of the mixer: valid, ready and one command item.
// Depends on wtm_pkg.
interface wtm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           op;
    logic [15:0]                          address;
    logic [1:0]                           voice;
    logic [2:0]                           reg_select;
    logic [27:0]                          value;
    logic signed [wtm_pkg::MIX_W-1:0]     prior_mix;
    logic                                 accumulate;

    modport source (output valid, op, address, voice, reg_select, value, prior_mix,
                    accumulate, input ready);
    modport sink (input valid, op, address, voice, reg_select, value, prior_mix,
                  accumulate, output ready);
endinterface

[sv/wtm_out_if.sv]
// Output channel of the mixer: valid, ready and one mixed sample.
// Depends on wtm_pkg.
interface wtm_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [wtm_pkg::MIX_W-1:0] mix_sample;

    modport source (output valid, mix_sample, input ready);
    modport sink (input valid, mix_sample, output ready);
endinterface

[sv/wtm_store.sv]
// Sample store: one write port and one read port with registered read data.
// Depends on wtm_pkg.
module wtm_store (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [wtm_pkg::SAMPLE_ADDR_BITS-1:0]  wr_addr,
    input  logic [wtm_pkg::SAMP_W-1:0]            wr_data,
    input  logic [wtm_pkg::SAMPLE_ADDR_BITS-1:0]  rd_addr,
    output logic [wtm_pkg::SAMP_W-1:0]            rd_data
);

    logic [wtm_pkg::SAMP_W-1:0] mem [2**wtm_pkg::SAMPLE_ADDR_BITS];
    logic [wtm_pkg::SAMP_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/wtm_mod_unit.sv]
// Iterative remainder unit: reduces the whole-sample overshoot of a voice
// position modulo the loop length, one quotient bit per cycle.
// Depends on wtm_pkg.
module wtm_mod_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  wtm_pkg::mod_req_t req,
    output wtm_pkg::mod_rsp_t rsp
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [wtm_pkg::CNT_W-1:0]        cnt_reg;
    logic [wtm_pkg::IDX_W-1:0]        quo_reg;
    logic [wtm_pkg::LOOP_W-1:0]       rem_reg;
    logic [wtm_pkg::LOOP_W-1:0]       div_reg;
    logic [wtm_pkg::LOOP_W:0]         trial;
    logic [wtm_pkg::LOOP_W-1:0]       rem_next;

    assign trial = {rem_reg, quo_reg[wtm_pkg::IDX_W-1]};

    always_comb
    begin
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = wtm_pkg::LOOP_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[wtm_pkg::LOOP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= wtm_pkg::CNT_W'(wtm_pkg::IDX_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == wtm_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            div_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[wtm_pkg::IDX_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

[sv/four_voice_wavetable_mixer.sv]
// Top level of the four-voice wavetable mixer: voice registers, sequencer,
// shared multiplier and accumulator. Depends on wtm_pkg, wtm_in_if,
// wtm_out_if, wtm_store and wtm_mod_unit.
//
//   channel  direction  carries
//   in_ch    sink       op, address, voice, reg_select, value, prior_mix, accumulate
//   out_ch   source     mix_sample, one per mix command
//
// A mix steps each voice in turn through reads of samples A and B, interpolation,
// scaling and accumulation, using the single store read port and the shared
// multiplier; it then loads the output register and advances each voice, through
// the loop remainder unit when its position passes the loop end. The block is not
// ready during a mix.
// Reset clears all voice registers; the sample store is not cleared.
// A stalled output holds the sequencer only at the output load step.
module four_voice_wavetable_mixer (
    input  logic      clk,
    input  logic      rst_n,
    wtm_in_if.sink    in_ch,
    wtm_out_if.source out_ch
);

    logic [wtm_pkg::BASE_W-1:0]  base_reg  [wtm_pkg::VOICES];
    logic [wtm_pkg::POS_W-1:0]   pos_reg   [wtm_pkg::VOICES];
    logic [wtm_pkg::RATE_W-1:0]  rate_reg  [wtm_pkg::VOICES];
    logic [wtm_pkg::VOL_W-1:0]   vol_reg   [wtm_pkg::VOICES];
    logic [wtm_pkg::LOOP_W-1:0]  lb_reg    [wtm_pkg::VOICES];
    logic [wtm_pkg::LOOP_W-1:0]  le_reg    [wtm_pkg::VOICES];

    wtm_pkg::state_t                       state_reg;
    wtm_pkg::state_t                       state_next;
    logic [wtm_pkg::VIDX_W-1:0]            v_reg;
    logic signed [wtm_pkg::DIFF_W-1:0]     sa_reg;
    logic signed [wtm_pkg::PROD_W-1:0]     prod_reg;
    logic signed [wtm_pkg::ACC_W-1:0]      acc_reg;
    logic signed [wtm_pkg::MIX_W-1:0]      prior_reg;
    logic                                  accum_flag_reg;
    logic                                  out_valid_reg;
    logic signed [wtm_pkg::MIX_W-1:0]      out_data_reg;
    logic [wtm_pkg::FRAC_BITS-1:0]         dlow_reg;

    logic                                  in_fire;
    logic                                  last_voice;
    logic [wtm_pkg::VIDX_W-1:0]            in_vidx;
    logic                                  in_voice_ok;

    logic [wtm_pkg::POS_W-1:0]             cur_pos;
    logic [wtm_pkg::IDX_W-1:0]             cur_idx;
    logic [wtm_pkg::FRAC_BITS-1:0]         cur_frac;
    logic [wtm_pkg::EXT_W-1:0]             lb_x;
    logic [wtm_pkg::EXT_W-1:0]             le_x;
    logic [wtm_pkg::EXT_W-1:0]             len_x;
    logic                                  loop_ok;
    logic [wtm_pkg::EXT_W-1:0]             nxt_x;
    logic [wtm_pkg::SAMPLE_ADDR_BITS-1:0]  addr_a;
    logic [wtm_pkg::SAMPLE_ADDR_BITS-1:0]  addr_b;
    logic [wtm_pkg::SAMPLE_ADDR_BITS-1:0]  rd_addr;
    logic [wtm_pkg::SAMP_W-1:0]            rd_data;
    logic signed [wtm_pkg::DIFF_W-1:0]     rd_sample;

    logic signed [wtm_pkg::DIFF_W-1:0]     mul_a;
    logic [wtm_pkg::FRAC_BITS-1:0]         mul_b;
    logic signed [wtm_pkg::PROD_W-1:0]     mul_p;
    logic signed [wtm_pkg::PROD_W-1:0]     prod_shift;
    logic signed [wtm_pkg::DIFF_W-1:0]     interp_s;

    logic signed [wtm_pkg::ACC_W-1:0]      total;
    logic signed [wtm_pkg::MIX_W-1:0]      clamped;

    logic [wtm_pkg::POS_W-1:0]             sum_pos;
    logic [wtm_pkg::EXT_W-1:0]             endf;
    logic                                  wrap_need;
    logic [wtm_pkg::EXT_W-1:0]             overshoot;
    logic [wtm_pkg::EXT_W-1:0]             rem_full;
    logic [wtm_pkg::EXT_W-1:0]             wrapped;

    wtm_pkg::mod_req_t                     mod_req;
    wtm_pkg::mod_rsp_t                     mod_rsp;

    assign in_ch.ready = (state_reg == wtm_pkg::S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign last_voice  = (v_reg == wtm_pkg::VIDX_W'(wtm_pkg::VOICES - 1));
    assign in_vidx     = wtm_pkg::VIDX_W'(in_ch.voice);
    assign in_voice_ok = ({30'd0, in_ch.voice} < 32'(wtm_pkg::VOICES));

    assign cur_pos  = pos_reg[v_reg];
    assign cur_idx  = cur_pos[wtm_pkg::POS_W-1:wtm_pkg::FRAC_BITS];
    assign cur_frac = cur_pos[wtm_pkg::FRAC_BITS-1:0];
    assign lb_x     = wtm_pkg::EXT_W'(lb_reg[v_reg]);
    assign le_x     = wtm_pkg::EXT_W'(le_reg[v_reg]);
    assign loop_ok  = (le_x > lb_x);
    assign len_x    = le_x - lb_x;

    always_comb
    begin
        nxt_x = wtm_pkg::EXT_W'(cur_idx) + wtm_pkg::EXT_W'(1);
        if (loop_ok && (nxt_x > le_x))
        begin
            nxt_x = nxt_x - len_x;
        end
    end

    assign addr_a  = wtm_pkg::SAMPLE_ADDR_BITS'(wtm_pkg::EXT_W'(base_reg[v_reg])
                                                + wtm_pkg::EXT_W'(cur_idx));
    assign addr_b  = wtm_pkg::SAMPLE_ADDR_BITS'(wtm_pkg::EXT_W'(base_reg[v_reg]) + nxt_x);
    assign rd_addr = (state_reg == wtm_pkg::S_RD_B) ? addr_b : addr_a;

    wtm_store u_store (
        .clk     (clk),
        .wr_en   (in_fire && (in_ch.op == wtm_pkg::OP_WRITE_SAMPLE)),
        .wr_addr (wtm_pkg::SAMPLE_ADDR_BITS'(in_ch.address)),
        .wr_data (in_ch.value[wtm_pkg::SAMP_W-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_sample  = wtm_pkg::DIFF_W'($signed(rd_data));
    assign prod_shift = prod_reg >>> wtm_pkg::FRAC_BITS;
    assign interp_s   = sa_reg + $signed(prod_shift[wtm_pkg::DIFF_W-1:0]);

    // The multiplier serves the blend by the fraction and then the volume.
    always_comb
    begin
        if (state_reg == wtm_pkg::S_SCALE)
        begin
            mul_a = interp_s;
            mul_b = wtm_pkg::FRAC_BITS'(vol_reg[v_reg]);
        end
        else
        begin
            mul_a = rd_sample - sa_reg;
            mul_b = cur_frac;
        end
    end

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    always_comb
    begin
        total = acc_reg;
        if (accum_flag_reg)
        begin
            total = acc_reg + wtm_pkg::ACC_W'(prior_reg);
        end
        if (total > wtm_pkg::MIX_MAX)
        begin
            clamped = wtm_pkg::MIX_W'(wtm_pkg::MIX_MAX);
        end
        else if (total < wtm_pkg::MIX_MIN)
        begin
            clamped = wtm_pkg::MIX_W'(wtm_pkg::MIX_MIN);
        end
        else
        begin
            clamped = wtm_pkg::MIX_W'(total);
        end
    end

    assign sum_pos   = wtm_pkg::POS_W'(wtm_pkg::EXT_W'(cur_pos)
                                       + wtm_pkg::EXT_W'(rate_reg[v_reg]));
    assign endf      = le_x << wtm_pkg::FRAC_BITS;
    assign wrap_need = loop_ok && (wtm_pkg::EXT_W'(sum_pos) > endf);
    assign overshoot = wtm_pkg::EXT_W'(sum_pos) - endf;
    assign rem_full  = wtm_pkg::EXT_W'({mod_rsp.rem, dlow_reg});
    assign wrapped   = (rem_full == '0) ? endf
                                        : endf - (len_x << wtm_pkg::FRAC_BITS) + rem_full;

    assign mod_req.start    = (state_reg == wtm_pkg::S_ADVANCE) && wrap_need;
    assign mod_req.dividend = overshoot[wtm_pkg::POS_W-1:wtm_pkg::FRAC_BITS];
    assign mod_req.divisor  = len_x[wtm_pkg::LOOP_W-1:0];

    wtm_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wtm_pkg::S_IDLE:
            begin
                if (in_fire && (in_ch.op == wtm_pkg::OP_MIX))
                begin
                    state_next = wtm_pkg::S_RD_A;
                end
            end
            wtm_pkg::S_RD_A:   state_next = wtm_pkg::S_RD_B;
            wtm_pkg::S_RD_B:   state_next = wtm_pkg::S_INTERP;
            wtm_pkg::S_INTERP: state_next = wtm_pkg::S_SCALE;
            wtm_pkg::S_SCALE:  state_next = wtm_pkg::S_ACCUM;
            wtm_pkg::S_ACCUM:
            begin
                state_next = last_voice ? wtm_pkg::S_OUTPUT : wtm_pkg::S_RD_A;
            end
            wtm_pkg::S_OUTPUT:
            begin
                if (!out_valid_reg)
                begin
                    state_next = wtm_pkg::S_ADVANCE;
                end
            end
            wtm_pkg::S_ADVANCE:
            begin
                if (wrap_need)
                begin
                    state_next = wtm_pkg::S_MOD_WAIT;
                end
                else if (last_voice)
                begin
                    state_next = wtm_pkg::S_IDLE;
                end
            end
            wtm_pkg::S_MOD_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    state_next = last_voice ? wtm_pkg::S_IDLE : wtm_pkg::S_ADVANCE;
                end
            end
            default:           state_next = wtm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wtm_pkg::S_IDLE;
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < wtm_pkg::VOICES; i++)
            begin
                base_reg[i] <= '0;
                pos_reg[i]  <= '0;
                rate_reg[i] <= '0;
                vol_reg[i]  <= '0;
                lb_reg[i]   <= '0;
                le_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                wtm_pkg::S_IDLE:
                begin
                    v_reg <= '0;
                    if (in_fire && (in_ch.op == wtm_pkg::OP_WRITE_VOICE) && in_voice_ok)
                    begin
                        case (in_ch.reg_select)
                            wtm_pkg::REG_BASE:
                                base_reg[in_vidx] <= in_ch.value[wtm_pkg::BASE_W-1:0];
                            wtm_pkg::REG_POSITION:
                                pos_reg[in_vidx] <= in_ch.value[wtm_pkg::POS_W-1:0];
                            wtm_pkg::REG_RATE:
                                rate_reg[in_vidx] <= in_ch.value[wtm_pkg::RATE_W-1:0];
                            wtm_pkg::REG_VOLUME:
                                vol_reg[in_vidx] <= in_ch.value[wtm_pkg::VOL_W-1:0];
                            wtm_pkg::REG_LOOP_BEGIN:
                                lb_reg[in_vidx] <= in_ch.value[wtm_pkg::LOOP_W-1:0];
                            wtm_pkg::REG_LOOP_END:
                                le_reg[in_vidx] <= in_ch.value[wtm_pkg::LOOP_W-1:0];
                            default:
                            begin
                            end
                        endcase
                    end
                end
                wtm_pkg::S_ACCUM:
                begin
                    v_reg <= last_voice ? '0 : v_reg + 1'b1;
                end
                wtm_pkg::S_OUTPUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                wtm_pkg::S_ADVANCE:
                begin
                    if (!wrap_need)
                    begin
                        pos_reg[v_reg] <= sum_pos;
                        v_reg          <= last_voice ? '0 : v_reg + 1'b1;
                    end
                end
                wtm_pkg::S_MOD_WAIT:
                begin
                    if (mod_rsp.done)
                    begin
                        pos_reg[v_reg] <= wtm_pkg::POS_W'(wrapped);
                        v_reg          <= last_voice ? '0 : v_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            wtm_pkg::S_IDLE:
            begin
                acc_reg        <= '0;
                prior_reg      <= in_ch.prior_mix;
                accum_flag_reg <= in_ch.accumulate;
            end
            wtm_pkg::S_RD_B:
            begin
                sa_reg <= rd_sample;
            end
            wtm_pkg::S_INTERP:
            begin
                prod_reg <= mul_p;
            end
            wtm_pkg::S_SCALE:
            begin
                prod_reg <= mul_p;
            end
            wtm_pkg::S_ACCUM:
            begin
                acc_reg <= acc_reg + wtm_pkg::ACC_W'(prod_reg);
            end
            wtm_pkg::S_OUTPUT:
            begin
                if (!out_valid_reg)
                begin
                    out_data_reg <= clamped;
                end
            end
            wtm_pkg::S_ADVANCE:
            begin
                dlow_reg <= overshoot[wtm_pkg::FRAC_BITS-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.mix_sample = out_data_reg;

    a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg != -wtm_pkg::MIX_W'(32768)))
        else $error("mixed sample outside the saturation range");

    a_mod_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wtm_pkg::S_MOD_WAIT) |-> (mod_rsp.busy || mod_rsp.done))
        else $error("waiting on an idle remainder unit");

    a_idle_mod: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !mod_rsp.busy)
        else $error("remainder unit busy while ready for a transfer");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> (wtm_pkg::EXT_W'(mod_rsp.rem) < len_x))
        else $error("loop remainder not below the loop length");

endmodule
